### hdl/sxf_pkg.sv
// ----------------------------------------------------------------------------
// sxf_pkg
// Shared types and constants of the s-expression stream framer.
// ----------------------------------------------------------------------------
package sxf_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int DEPTH_BITS      = 16;
  localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_ESCAPE    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_UNTERM    = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] error_code;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } scan_out_t;

endpackage

### hdl/sxf_scanner.sv
// ----------------------------------------------------------------------------
// sxf_scanner
// Mode machine, depth and length counters; one character per accepted word,
// producing up to two result words.
// ----------------------------------------------------------------------------
module sxf_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          char_in,
  input  logic                end_of_stream,
  input  logic                interactive_mode,
  output sxf_pkg::scan_out_t  scan
);

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] M_TOP          = 3'd0;
  localparam logic [MODE_W-1:0] M_LIST         = 3'd1;
  localparam logic [MODE_W-1:0] M_STRING       = 3'd2;
  localparam logic [MODE_W-1:0] M_ESCAPE       = 3'd3;
  localparam logic [MODE_W-1:0] M_TOKEN        = 3'd4;
  localparam logic [MODE_W-1:0] M_COMMENT_TOP  = 3'd5;
  localparam logic [MODE_W-1:0] M_COMMENT_LIST = 3'd6;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_A   = 8'h61;

  localparam logic [sxf_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [sxf_pkg::LEN_W-1:0] LEN_MAX =
    sxf_pkg::LEN_W'(sxf_pkg::MAX_FRAME_BYTES);
  localparam logic [sxf_pkg::LEN_W-1:0] LEN_ONE = sxf_pkg::LEN_W'(1);
  localparam logic [sxf_pkg::DEPTH_BITS-1:0] DEPTH_ONE = sxf_pkg::DEPTH_BITS'(1);

  logic [MODE_W-1:0]              mode_r, mode_nxt;
  logic [sxf_pkg::DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [sxf_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic                           sil_r, sil_nxt;

  logic [sxf_pkg::LEN_W-1:0]      cur_len;
  logic [sxf_pkg::DEPTH_BITS-1:0] depth_dec;
  logic                           emit_req;
  logic [7:0]                     emit_byte;
  sxf_pkg::res_t                  r0, r1;
  logic [1:0]                     n;

  function automatic sxf_pkg::res_t end_res(input logic [1:0] err);
    sxf_pkg::res_t r;
    r.out_byte   = 8'h00;
    r.byte_valid = 1'b0;
    r.frame_end  = 1'b1;
    r.error_code = err;
    return r;
  endfunction

  function automatic sxf_pkg::res_t byte_res(input logic [7:0] b);
    sxf_pkg::res_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.frame_end  = 1'b0;
    r.error_code = sxf_pkg::ERR_OK;
    return r;
  endfunction

  assign cur_len   = (mode_r <= M_COMMENT_LIST) ? len_r : '0;
  assign depth_dec = (depth_r != '0) ? depth_r - DEPTH_ONE : depth_r;

  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    len_nxt   = cur_len;
    sil_nxt   = sil_r;
    emit_req  = 1'b0;
    emit_byte = char_in;
    r0        = '0;
    r1        = '0;
    n         = 2'd0;
    if (mode_r > M_COMMENT_LIST) begin
      mode_nxt  = M_TOP;
      depth_nxt = '0;
      sil_nxt   = 1'b0;
    end

    if (end_of_stream) begin
      if (!interactive_mode) begin
        case (mode_r)
          M_TOKEN: begin
            r0 = end_res(sxf_pkg::ERR_OK);
            n  = 2'd1;
          end
          M_LIST, M_STRING, M_ESCAPE, M_COMMENT_LIST: begin
            r0 = end_res(sxf_pkg::ERR_UNTERM);
            n  = 2'd1;
          end
          default: begin
            if (cur_len != '0) begin
              r0 = end_res(sxf_pkg::ERR_UNTERM);
              n  = 2'd1;
            end
          end
        endcase
        mode_nxt  = M_TOP;
        depth_nxt = '0;
        len_nxt   = '0;
        sil_nxt   = 1'b0;
      end
    end else begin
      case (mode_r)
        M_LIST: begin
          case (char_in)
            CH_LPAREN: begin
              emit_req = 1'b1;
              if (depth_r != DEPTH_MAX) depth_nxt = depth_r + DEPTH_ONE;
            end
            CH_RPAREN: begin
              emit_req = 1'b1;
              depth_nxt = depth_dec;
            end
            CH_DQUOTE: begin
              emit_req = 1'b1;
              sil_nxt  = 1'b1;
              mode_nxt = M_STRING;
            end
            CH_SEMI: mode_nxt = M_COMMENT_LIST;
            CH_NL:   emit_req = interactive_mode;
            default: emit_req = 1'b1;
          endcase
        end
        M_STRING: begin
          case (char_in)
            CH_DQUOTE: begin
              emit_req = 1'b1;
              if (sil_r) mode_nxt = M_LIST;
            end
            CH_BSLASH: mode_nxt = M_ESCAPE;
            default:   emit_req = 1'b1;
          endcase
        end
        M_ESCAPE: begin
          emit_req = 1'b1;
          mode_nxt = M_STRING;
          case (char_in)
            CH_LC_N:   emit_byte = CH_NL;
            CH_LC_R:   emit_byte = CH_CR;
            CH_LC_A:   emit_byte = CH_BEL;
            CH_BSLASH: emit_byte = CH_BSLASH;
            default: begin
              emit_req = 1'b0;
              r0 = end_res(sxf_pkg::ERR_ESCAPE);
              n  = 2'd1;
              mode_nxt  = M_TOP;
              depth_nxt = '0;
              len_nxt   = '0;
              sil_nxt   = 1'b0;
            end
          endcase
        end
        M_TOKEN: begin
          case (char_in)
            CH_LPAREN, CH_RPAREN, CH_DQUOTE: begin
              // close the token, then reopen a frame with this delimiter
              r0 = end_res(sxf_pkg::ERR_OK);
              r1 = byte_res(char_in);
              n  = 2'd2;
              len_nxt   = LEN_ONE;
              depth_nxt = '0;
              sil_nxt   = 1'b0;
              case (char_in)
                CH_LPAREN: begin
                  depth_nxt = DEPTH_ONE;
                  mode_nxt  = M_LIST;
                end
                CH_DQUOTE: mode_nxt = M_STRING;
                default:   mode_nxt = M_TOKEN;
              endcase
            end
            CH_SPACE, CH_TAB, CH_NL: begin
              r0 = end_res(sxf_pkg::ERR_OK);
              n  = 2'd1;
              mode_nxt  = M_TOP;
              depth_nxt = '0;
              len_nxt   = '0;
              sil_nxt   = 1'b0;
            end
            default: emit_req = 1'b1;
          endcase
        end
        M_COMMENT_TOP: begin
          if (char_in == CH_NL) begin
            mode_nxt = M_TOP;
            if (cur_len != '0) begin
              r0 = end_res(sxf_pkg::ERR_OK);
              n  = 2'd1;
              depth_nxt = '0;
              len_nxt   = '0;
              sil_nxt   = 1'b0;
            end
          end
        end
        M_COMMENT_LIST: begin
          if (char_in == CH_NL) begin
            mode_nxt = M_LIST;
            emit_req = interactive_mode;
          end
        end
        default: begin
          case (char_in)
            CH_NL: begin
              if (cur_len != '0) begin
                r0 = end_res(sxf_pkg::ERR_OK);
                n  = 2'd1;
                mode_nxt  = M_TOP;
                depth_nxt = '0;
                len_nxt   = '0;
                sil_nxt   = 1'b0;
              end
            end
            CH_SPACE, CH_TAB: ;
            CH_SQUOTE: emit_req = 1'b1;
            CH_LPAREN: begin
              emit_req  = 1'b1;
              depth_nxt = DEPTH_ONE;
              mode_nxt  = M_LIST;
            end
            CH_DQUOTE: begin
              emit_req = 1'b1;
              sil_nxt  = 1'b0;
              mode_nxt = M_STRING;
            end
            CH_SEMI: mode_nxt = M_COMMENT_TOP;
            default: begin
              emit_req = 1'b1;
              mode_nxt = M_TOKEN;
            end
          endcase
        end
      endcase

      if (emit_req) begin
        if (cur_len >= LEN_MAX) begin
          r0 = end_res(sxf_pkg::ERR_OVERFLOW);
          n  = 2'd1;
          mode_nxt  = M_TOP;
          depth_nxt = '0;
          len_nxt   = '0;
          sil_nxt   = 1'b0;
        end else begin
          r0 = byte_res(emit_byte);
          n  = 2'd1;
          len_nxt = cur_len + LEN_ONE;
          // closing paren of the outer list or closing quote of a bare string
          if ((mode_r == M_LIST && char_in == CH_RPAREN && depth_dec == '0) ||
              (mode_r == M_STRING && char_in == CH_DQUOTE && !sil_r)) begin
            r0.frame_end = 1'b1;
            mode_nxt  = M_TOP;
            depth_nxt = '0;
            len_nxt   = '0;
            sil_nxt   = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_TOP;
      depth_r <= '0;
      len_r   <= '0;
      sil_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      len_r   <= len_nxt;
      sil_r   <= sil_nxt;
    end
  end

  assign scan.r0 = r0;
  assign scan.r1 = r1;
  assign scan.n  = n;

endmodule

### hdl/sxf_out_fifo.sv
// ----------------------------------------------------------------------------
// sxf_out_fifo
// Result queue; takes up to two words per cycle, delivers one when the reader is ready.
// ----------------------------------------------------------------------------
module sxf_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  sxf_pkg::scan_out_t         wr,
  output logic                       room,
  output logic                       rd_valid,
  input  logic                       rd_ready,
  output sxf_pkg::res_t              rd_data
);

  localparam logic [sxf_pkg::PTR_W-1:0] PTR_ONE = sxf_pkg::PTR_W'(1);
  localparam logic [sxf_pkg::CNT_W-1:0] ROOM_LIMIT =
    sxf_pkg::CNT_W'(sxf_pkg::FIFO_DEPTH - 2);

  sxf_pkg::res_t                mem [sxf_pkg::FIFO_DEPTH];
  logic [sxf_pkg::PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [sxf_pkg::PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [sxf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [1:0]                   n_wr;
  logic                         pop;

  assign n_wr     = wr_en ? wr.n : 2'd0;
  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (cnt_r != '0);
  assign room     = (cnt_r <= ROOM_LIMIT);
  assign rd_data  = mem[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + sxf_pkg::PTR_W'(n_wr);
  assign rd_ptr_nxt = pop ? rd_ptr_r + PTR_ONE : rd_ptr_r;
  assign cnt_nxt    = cnt_r + sxf_pkg::CNT_W'(n_wr) - sxf_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) mem[wr_ptr_r] <= wr.r0;
    if (n_wr == 2'd2) mem[wr_ptr_r + PTR_ONE] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/sexpr_stream_framer.sv
// ----------------------------------------------------------------------------
// sexpr_stream_framer
// Cuts a character stream into top-level s-expression frames.
//
//   channel  dir  tdata                          tuser          tlast
//   in_      in   [7:0] char_in                  end_of_stream  -
//   out_     out  [7:0] out_byte, [9:8] err      byte_valid     frame_end
//   cfg_     in   cfg_wdata = interactive_mode   -              -
//
// One word per cycle unless stalled; mode machine and counters are registered.
// A word with two results (token closed by a delimiter) queues both words.
// Input stalls only when the result queue holds more than two words.
// Synchronous active-low reset returns to idle between frames, file mode.
// ----------------------------------------------------------------------------
module sexpr_stream_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] error_code
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic               interactive_r;
  logic               in_acc;
  sxf_pkg::scan_out_t scan;
  sxf_pkg::res_t      head;

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interactive_r <= 1'b0;
    end else if (cfg_we) begin
      interactive_r <= cfg_wdata;
    end
  end

  sxf_scanner u_scanner (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_acc),
    .char_in          (in_tdata),
    .end_of_stream    (in_tuser),
    .interactive_mode (interactive_r),
    .scan             (scan)
  );

  sxf_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr       (scan),
    .room     (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {6'b0, head.error_code, head.out_byte};
  assign out_tuser = head.byte_valid;
  assign out_tlast = head.frame_end;

  a_two_res_first_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && scan.n == 2'd2) |-> (scan.r0.frame_end && !scan.r0.byte_valid))
    else $error("second result without a leading frame end");

  a_err_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && scan.n != 2'd0 && scan.r0.error_code != sxf_pkg::ERR_OK)
      |-> scan.r0.frame_end)
    else $error("error code on a non-final word");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && scan.n != 2'd0) |=> out_tvalid)
    else $error("result word lost");

  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty queue");

endmodule

### tb/sv/sxf_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sxf_tb_pkg
// Character codes and the frame scoreboard for the framer testbench. The
// scoreboard runs its own copy of the scan machine on every accepted word,
// queues the frame words the block owes, and checks each delivered word
// against the oldest one.
// ----------------------------------------------------------------------------
package sxf_tb_pkg;

  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ESC_A  = 8'h61;
  localparam logic [7:0] CH_ESC_N  = 8'h6E;
  localparam logic [7:0] CH_ESC_R  = 8'h72;

  localparam longint MAX_DEPTH = (64'd1 << sxf_pkg::DEPTH_BITS) - 1;

  typedef enum logic [3:0] {
    SCAN_TOP,
    SCAN_LIST,
    SCAN_STRING,
    SCAN_ESCAPE,
    SCAN_TOKEN,
    SCAN_NOTE_TOP,
    SCAN_NOTE_LIST
  } scan_e;

  class frame_scoreboard;
    sxf_pkg::res_t owed_q[$];
    bit     interactive;
    scan_e  scan;
    longint depth;
    int     flen;
    bit     str_in_list;
    int     errors;
    int     noted;

    function new();
      interactive = 1'b0;
      errors = 0;
      go_idle();
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void go_idle();
      scan = SCAN_TOP;
      depth = 0;
      flen = 0;
      str_in_list = 1'b0;
    endfunction

    function void put(logic [7:0] b, logic v, logic e, logic [1:0] err);
      sxf_pkg::res_t r;
      r.out_byte = b;
      r.byte_valid = v;
      r.frame_end = e;
      r.error_code = err;
      owed_q.push_back(r);
      noted++;
    endfunction

    function void close_frame(logic [1:0] err);
      put(8'h00, 1'b0, 1'b1, err);
      go_idle();
    endfunction

    function void mark_frame_end();
      sxf_pkg::res_t r;
      r = owed_q.pop_back();
      r.frame_end = 1'b1;
      owed_q.push_back(r);
      go_idle();
    endfunction

    function bit emit(logic [7:0] c);
      if (flen >= sxf_pkg::MAX_FRAME_BYTES) begin
        close_frame(sxf_pkg::ERR_OVERFLOW);
        return 1'b0;
      end
      put(c, 1'b1, 1'b0, sxf_pkg::ERR_OK);
      flen++;
      return 1'b1;
    endfunction

    function void at_top(logic [7:0] c);
      case (c)
        CH_NL: if (flen > 0) close_frame(sxf_pkg::ERR_OK);
        CH_SPACE, CH_TAB: ;
        CH_QUOTE: void'(emit(c));
        CH_LPAREN: if (emit(c)) begin
          depth = 1;
          scan = SCAN_LIST;
        end
        CH_DQUOTE: if (emit(c)) begin
          str_in_list = 1'b0;
          scan = SCAN_STRING;
        end
        CH_SEMI: scan = SCAN_NOTE_TOP;
        default: if (emit(c)) scan = SCAN_TOKEN;
      endcase
    endfunction

    function void in_list(logic [7:0] c);
      case (c)
        CH_LPAREN: if (emit(c)) begin
          if (depth < MAX_DEPTH) depth++;
        end
        CH_RPAREN: if (emit(c)) begin
          if (depth > 0) depth--;
          if (depth == 0) mark_frame_end();
        end
        CH_DQUOTE: if (emit(c)) begin
          str_in_list = 1'b1;
          scan = SCAN_STRING;
        end
        CH_SEMI: scan = SCAN_NOTE_LIST;
        CH_NL: if (interactive) void'(emit(c));
        default: void'(emit(c));
      endcase
    endfunction

    function void in_string(logic [7:0] c);
      if (c == CH_DQUOTE) begin
        if (emit(c)) begin
          if (str_in_list) scan = SCAN_LIST;
          else mark_frame_end();
        end
      end else if (c == CH_BSLASH) begin
        scan = SCAN_ESCAPE;
      end else begin
        void'(emit(c));
      end
    endfunction

    function void in_escape(logic [7:0] c);
      logic [7:0] d;
      case (c)
        CH_ESC_N: d = CH_NL;
        CH_ESC_R: d = CH_CR;
        CH_ESC_A: d = CH_BEL;
        CH_BSLASH: d = CH_BSLASH;
        default: begin
          close_frame(sxf_pkg::ERR_ESCAPE);
          return;
        end
      endcase
      if (emit(d)) scan = SCAN_STRING;
    endfunction

    function void in_token(logic [7:0] c);
      case (c)
        CH_LPAREN, CH_RPAREN, CH_DQUOTE: begin
          close_frame(sxf_pkg::ERR_OK);
          at_top(c);
        end
        CH_SPACE, CH_TAB, CH_NL: close_frame(sxf_pkg::ERR_OK);
        default: void'(emit(c));
      endcase
    endfunction

    function void at_eof();
      case (scan)
        SCAN_TOKEN: close_frame(sxf_pkg::ERR_OK);
        SCAN_LIST, SCAN_STRING, SCAN_ESCAPE, SCAN_NOTE_LIST:
          close_frame(sxf_pkg::ERR_UNTERM);
        default: if (flen > 0) close_frame(sxf_pkg::ERR_UNTERM);
                 else go_idle();
      endcase
    endfunction

    // Returns 1 when the word moved the scan machine or produced output.
    function bit note_word(logic [7:0] c, logic eos);
      scan_e was_scan;
      int    was_len;
      was_scan = scan;
      was_len = flen;
      noted = 0;
      if (eos) begin
        if (!interactive) at_eof();
      end else begin
        case (scan)
          SCAN_LIST: in_list(c);
          SCAN_STRING: in_string(c);
          SCAN_ESCAPE: in_escape(c);
          SCAN_TOKEN: in_token(c);
          SCAN_NOTE_TOP: if (c == CH_NL) begin
            scan = SCAN_TOP;
            at_top(c);
          end
          SCAN_NOTE_LIST: if (c == CH_NL) begin
            scan = SCAN_LIST;
            in_list(c);
          end
          default: at_top(c);
        endcase
      end
      return (noted > 0) || (scan != was_scan) || (flen != was_len);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_word(sxf_pkg::res_t got);
      sxf_pkg::res_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("word with nothing owed: byte=%02h valid=%0b last=%0b err=%0d",
                         got.out_byte, got.byte_valid, got.frame_end, got.error_code));
        return;
      end
      want = owed_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %0b, want %0b", got.byte_valid, want.byte_valid));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
    endtask
  endclass

endpackage

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the s-expression framer. Directed frames cover every scan
// mode, every escape, end of input in list, escape and token mode; random
// phases in file and console mode then send well-formed frames mixed with
// broken ones and noise, with random gaps and long stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  sxf_tb_pkg::frame_scoreboard sb = new();
  sxf_pkg::res_t got_word;
  int   sent_words = 0;
  int   hold_req = 0;
  bit   calm = 1'b0;

  sexpr_stream_framer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      void'(sb.note_word(in_tdata, in_tuser));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_word.out_byte = out_tdata[7:0];
      got_word.error_code = out_tdata[9:8];
      got_word.byte_valid = out_tuser;
      got_word.frame_end = out_tlast;
      sb.check_word(got_word);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random gaps, plus a counted hold when one is requested.
  initial begin
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm) gap_left = pick_gap();
      end
    end
  end

  task automatic send_word(logic [7:0] c, logic eos);
    int gap;
    gap = calm ? 0 : pick_gap();
    sent_words++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.interactive = v;
  endtask

  function automatic logic [7:0] atom_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 25));
    c = 8'($urandom_range(0, 255));
    if (c inside {sxf_tb_pkg::CH_LPAREN, sxf_tb_pkg::CH_RPAREN,
                  sxf_tb_pkg::CH_DQUOTE, sxf_tb_pkg::CH_SPACE,
                  sxf_tb_pkg::CH_TAB, sxf_tb_pkg::CH_NL,
                  sxf_tb_pkg::CH_SEMI, sxf_tb_pkg::CH_QUOTE})
      c = c ^ 8'h80;
    return c;
  endfunction

  function automatic logic [7:0] string_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'h41 + 8'($urandom_range(0, 57));
    c = 8'($urandom_range(0, 255));
    if (c == sxf_tb_pkg::CH_DQUOTE || c == sxf_tb_pkg::CH_BSLASH) c = c ^ 8'h80;
    return c;
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 2))
      0: return sxf_tb_pkg::CH_SPACE;
      1: return sxf_tb_pkg::CH_TAB;
      default: return sxf_tb_pkg::CH_NL;
    endcase
  endfunction

  task automatic gen_token();
    repeat ($urandom_range(1, 6)) send_word(atom_char(), 1'b0);
  endtask

  task automatic gen_string();
    send_word(sxf_tb_pkg::CH_DQUOTE, 1'b0);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(sxf_tb_pkg::CH_BSLASH, 1'b0);
        case ($urandom_range(0, 3))
          0: send_word(sxf_tb_pkg::CH_ESC_N, 1'b0);
          1: send_word(sxf_tb_pkg::CH_ESC_R, 1'b0);
          2: send_word(sxf_tb_pkg::CH_ESC_A, 1'b0);
          default: send_word(sxf_tb_pkg::CH_BSLASH, 1'b0);
        endcase
      end else begin
        send_word(string_char(), 1'b0);
      end
    end
    send_word(sxf_tb_pkg::CH_DQUOTE, 1'b0);
  endtask

  task automatic gen_list();
    int open;
    int steps;
    send_word(sxf_tb_pkg::CH_LPAREN, 1'b0);
    open = 1;
    steps = $urandom_range(1, 10);
    while (open > 0) begin
      if (steps == 0) begin
        send_word(sxf_tb_pkg::CH_RPAREN, 1'b0);
        open--;
      end else begin
        steps--;
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            gen_token();
            send_word(pick_space(), 1'b0);
          end
          3: gen_string();
          4, 5: if (open < 5) begin
            send_word(sxf_tb_pkg::CH_LPAREN, 1'b0);
            open++;
          end
          6: begin
            send_word(sxf_tb_pkg::CH_RPAREN, 1'b0);
            open--;
          end
          7: begin
            send_word(sxf_tb_pkg::CH_QUOTE, 1'b0);
            gen_token();
            send_word(sxf_tb_pkg::CH_SPACE, 1'b0);
          end
          8: begin
            send_word(sxf_tb_pkg::CH_SEMI, 1'b0);
            gen_token();
            send_word(sxf_tb_pkg::CH_NL, 1'b0);
          end
          default: send_word(pick_space(), 1'b0);
        endcase
      end
    end
  endtask

  task automatic gen_frame();
    case ($urandom_range(0, 6))
      0, 1: gen_list();
      2: begin
        gen_token();
        send_word(pick_space(), 1'b0);
      end
      3: begin
        // close a token with a delimiter, then finish what it opened
        gen_token();
        case ($urandom_range(0, 2))
          0: begin
            send_word(sxf_tb_pkg::CH_LPAREN, 1'b0);
            gen_token();
            send_word(sxf_tb_pkg::CH_RPAREN, 1'b0);
          end
          1: begin
            send_word(sxf_tb_pkg::CH_DQUOTE, 1'b0);
            send_word(string_char(), 1'b0);
            send_word(sxf_tb_pkg::CH_DQUOTE, 1'b0);
          end
          default: begin
            send_word(sxf_tb_pkg::CH_RPAREN, 1'b0);
            send_word(sxf_tb_pkg::CH_SPACE, 1'b0);
          end
        endcase
      end
      4: gen_string();
      5: begin
        send_word(sxf_tb_pkg::CH_QUOTE, 1'b0);
        if ($urandom_range(0, 1)) gen_list();
        else begin
          gen_token();
          send_word(pick_space(), 1'b0);
        end
      end
      default: begin
        send_word(sxf_tb_pkg::CH_SEMI, 1'b0);
        gen_token();
        send_word(sxf_tb_pkg::CH_NL, 1'b0);
      end
    endcase
  endtask

  task automatic gen_item();
    case ($urandom_range(0, 19))
      14: send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      15: begin
        send_word(sxf_tb_pkg::CH_LPAREN, 1'b0);
        gen_token();
        send_eos();
      end
      16: begin
        send_word(sxf_tb_pkg::CH_DQUOTE, 1'b0);
        send_word(string_char(), 1'b0);
        send_word(sxf_tb_pkg::CH_BSLASH, 1'b0);
        send_word(atom_char(), 1'b0);
      end
      17: send_eos();
      18: repeat (5) send_word(8'($urandom_range(0, 255)), 1'b0);
      19: send_word(sxf_tb_pkg::CH_NL, 1'b0);
      default: begin
        gen_frame();
        if ($urandom_range(0, 3) == 0) send_word(pick_space(), 1'b0);
      end
    endcase
  endtask

  initial begin
    int target;
    bit held;
    bit paused;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(1'b0);
    send_text("((a\n)) ");
    send_text("\"\\n\\r\\a\\\\\" ");
    send_text("'x\n;c\nab()) ");
    send_text("\"\\q");
    send_word(8'hFF, 1'b0);
    send_eos();
    send_text("(x");
    send_eos();
    send_text("'");
    send_eos();
    send_eos();
    send_text("(;c");
    send_eos();
    send_text("\"a\\");
    send_eos();

    settle();
    write_mode(1'b1);
    send_text("(x\n");
    send_eos();
    send_text(")\n");

    held = 1'b0;
    paused = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_mode(ph % 2 == 0);
      target = sent_words + 225;
      while (sent_words < target) begin
        if (ph == 1 && !held && sent_words > target - 150) begin
          hold_req = 300;
          held = 1'b1;
        end
        if (ph == 2 && !paused && sent_words > target - 120) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 2) == 0);
        gen_item();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hdl/sxf_pkg.sv
hdl/sxf_scanner.sv
hdl/sxf_out_fifo.sv
hdl/sexpr_stream_framer.sv
tb/sv/sxf_tb_pkg.sv
tb/sv/tb.sv
